>>> rtl/atb_pkg.sv
`timescale 1ns / 1ps

package atb_pkg;

	// Fixed triangle vertices are Q2.16
	localparam int VERT_FRAC = 16;
	localparam int FRAME_BITS = 12;
	localparam int MAT_W = 32;
	// Transformed coordinate width: |X| < 2^50 for any 32-bit matrix
	localparam int TX_W = 51;
	localparam int ADDR_W = 5;
	localparam int NSTG = 9;

	// round(sqrt3 * 65536)
	localparam logic signed [17:0] SQRT3_VQ = 18'sd113512;
	localparam logic [MAT_W-1:0] MAT_ONE = 32'h0001_0000;
	localparam logic [FRAME_BITS-1:0] FRAME_W_RST = 12'd1280;
	localparam logic [FRAME_BITS-1:0] FRAME_H_RST = 12'd720;

	typedef enum logic [2:0] {
		REG_MAT_A   = 3'd0,
		REG_MAT_B   = 3'd1,
		REG_MAT_C   = 3'd2,
		REG_MAT_D   = 3'd3,
		REG_MAT_E   = 3'd4,
		REG_MAT_F   = 3'd5,
		REG_FRAME_W = 3'd6,
		REG_FRAME_H = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_NONE  = 2'd0,
		ST_X_OUT = 2'd1,
		ST_Y_OUT = 2'd2
	} edge_st_t;

	// Per-item sideband that rides along with the multiplier stages
	typedef struct packed {
		logic [2:0] cnt;
		logic [2:0] dypos;
		edge_st_t   st;
	} edge_side_t;

	// Per-stage load enables, adv9 is the MSB
	typedef struct packed {
		logic adv9;
		logic adv8;
		logic adv7;
		logic adv6;
		logic adv5;
		logic adv4;
		logic adv3;
		logic adv2;
		logic adv1;
	} pipe_adv_t;

endpackage

>>> rtl/affine_triangle_hit_and_bounds_test.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// pt        in         pt_valid/pt_stall    point_x, point_y
// res       out        res_valid/res_stall  inside_res, edge_status
// apb       in         psel/penable/pready  paddr, pwdata, prdata
//
// Nine register stages, one transfer accepted per cycle while res_stall does not back the pipeline up.
// No stage holds an item on its own, so only res_stall lowers the rate.
// Reset clears all stage valids and loads the identity transform and 1280x720 frame.
// Each stage loads when it is empty or the next one loads, so bubbles fill under stall.

module affine_triangle_hit_and_bounds_test #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pt_valid,
	output logic                        pt_stall,
	input  logic [COORD_BITS-1:0]       point_x,
	input  logic [COORD_BITS-1:0]       point_y,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic                        inside_res,
	output logic [1:0]                  edge_status,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [atb_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import atb_pkg::*;

	localparam int TFRAC = FRAC_BITS + VERT_FRAC;
	localparam int PT_W  = COORD_BITS + TFRAC + 1;
	localparam int FR_W  = FRAME_BITS + TFRAC + 1;
	localparam int CW_A  = (TX_W > PT_W) ? TX_W : PT_W;
	localparam int CW    = (CW_A > FR_W) ? CW_A : FR_W;
	localparam int DW    = CW + 1;

	logic signed [MAT_W-1:0]  mat_a_q, mat_b_q, mat_c_q, mat_d_q, mat_e_q, mat_f_q;
	logic [FRAME_BITS-1:0]    frame_w_q, frame_h_q;
	logic                     wr_en;
	reg_idx_t                 reg_idx;

	logic [NSTG:1]            stg_vld_q;
	logic [NSTG+1:1]          rdy;
	pipe_adv_t                adv;

	logic signed [TX_W-1:0]   tx_s2 [3];
	logic signed [TX_W-1:0]   ty_s2 [3];
	logic [COORD_BITS-1:0]    px_s2, py_s2;
	logic signed [DW-1:0]     dy_s3 [3];
	logic signed [DW-1:0]     la_s3 [3];
	logic signed [DW-1:0]     ra_s3 [3];
	logic signed [DW-1:0]     rb_s3 [3];
	edge_side_t               side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;
	logic signed [2*DW-1:0]   lhs_s8 [3];
	logic signed [2*DW-1:0]   rhs_s8 [3];
	logic                     par_c;
	logic                     inside_s9;
	edge_st_t                 status_s9;

	// Register file
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_a_q   <= MAT_ONE;
			mat_b_q   <= '0;
			mat_c_q   <= '0;
			mat_d_q   <= '0;
			mat_e_q   <= MAT_ONE;
			mat_f_q   <= '0;
			frame_w_q <= FRAME_W_RST;
			frame_h_q <= FRAME_H_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MAT_A:   mat_a_q   <= pwdata;
				REG_MAT_B:   mat_b_q   <= pwdata;
				REG_MAT_C:   mat_c_q   <= pwdata;
				REG_MAT_D:   mat_d_q   <= pwdata;
				REG_MAT_E:   mat_e_q   <= pwdata;
				REG_MAT_F:   mat_f_q   <= pwdata;
				REG_FRAME_W: frame_w_q <= pwdata[FRAME_BITS-1:0];
				REG_FRAME_H: frame_h_q <= pwdata[FRAME_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MAT_A:   prdata = mat_a_q;
			REG_MAT_B:   prdata = mat_b_q;
			REG_MAT_C:   prdata = mat_c_q;
			REG_MAT_D:   prdata = mat_d_q;
			REG_MAT_E:   prdata = mat_e_q;
			REG_MAT_F:   prdata = mat_f_q;
			REG_FRAME_W: prdata = 32'(frame_w_q);
			REG_FRAME_H: prdata = 32'(frame_h_q);
			default:     prdata = '0;
		endcase
	end

	// Stage load enables: a stage loads when empty or when the next one loads
	always_comb begin
		rdy[NSTG+1] = !res_stall;
		for (int k = NSTG; k >= 1; k--) begin
			rdy[k] = !stg_vld_q[k] || rdy[k+1];
		end
	end

	assign adv      = pipe_adv_t'(rdy[NSTG:1]);
	assign pt_stall = !rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= '0;
		end else begin
			if (rdy[1]) begin
				stg_vld_q[1] <= pt_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (rdy[k]) begin
					stg_vld_q[k] <= stg_vld_q[k-1];
				end
			end
		end
	end

	// Stages 1-2: vertex transform
	atb_xform #(
		.COORD_BITS (COORD_BITS)
	) u_xform (
		.clk     (clk),
		.adv     (adv),
		.mat_a   (mat_a_q),
		.mat_b   (mat_b_q),
		.mat_c   (mat_c_q),
		.mat_d   (mat_d_q),
		.mat_e   (mat_e_q),
		.mat_f   (mat_f_q),
		.point_x (point_x),
		.point_y (point_y),
		.tx_s2   (tx_s2),
		.ty_s2   (ty_s2),
		.px_s2   (px_s2),
		.py_s2   (py_s2)
	);

	// Stage 3: edge differences, crossing candidates, frame status
	atb_setup #(
		.COORD_BITS (COORD_BITS),
		.TFRAC      (TFRAC),
		.CW         (CW),
		.DW         (DW)
	) u_setup (
		.clk          (clk),
		.adv          (adv),
		.tx_s2        (tx_s2),
		.ty_s2        (ty_s2),
		.px_s2        (px_s2),
		.py_s2        (py_s2),
		.frame_width  (frame_w_q),
		.frame_height (frame_h_q),
		.dy_s3        (dy_s3),
		.la_s3        (la_s3),
		.ra_s3        (ra_s3),
		.rb_s3        (rb_s3),
		.side_s3      (side_s3)
	);

	// Stages 4-8: exact cross-multiplication, two products per edge
	for (genvar g = 0; g < 3; g++) begin : g_edge
		atb_wmul #(
			.DW (DW)
		) u_lhs (
			.clk     (clk),
			.adv     (adv),
			.op_a    (la_s3[g]),
			.op_b    (dy_s3[g]),
			.prod_s8 (lhs_s8[g])
		);
		atb_wmul #(
			.DW (DW)
		) u_rhs (
			.clk     (clk),
			.adv     (adv),
			.op_a    (ra_s3[g]),
			.op_b    (rb_s3[g]),
			.prod_s8 (rhs_s8[g])
		);
	end

	// Sideband follows the multiplier stages
	always_ff @(posedge clk) begin
		if (adv.adv4) side_s4 <= side_s3;
		if (adv.adv5) side_s5 <= side_s4;
		if (adv.adv6) side_s6 <= side_s5;
		if (adv.adv7) side_s7 <= side_s6;
		if (adv.adv8) side_s8 <= side_s7;
	end

	// Stage 9: crossing decision and parity
	always_comb begin
		logic hit_edge;
		par_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			hit_edge = side_s8.dypos[i] ? (lhs_s8[i] < rhs_s8[i]) : (rhs_s8[i] < lhs_s8[i]);
			if (side_s8.cnt[i] && hit_edge) begin
				par_c = ~par_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.adv9) begin
			inside_s9 <= par_c;
			status_s9 <= side_s8.st;
		end
	end

	assign res_valid   = stg_vld_q[NSTG];
	assign inside_res  = inside_s9;
	assign edge_status = status_s9;

`ifndef SYNTHESIS
	// Input backs up only when every stage holds an item and the output is stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pt_stall |-> ((&stg_vld_q) && res_stall))
		else $error("input stalled with room in the pipeline");

	// No transfer on either side: item count in flight unchanged
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!(pt_valid && !pt_stall) && !(res_valid && !res_stall))
		|=> ($countones(stg_vld_q) == $countones($past(stg_vld_q))))
		else $error("item lost or invented inside the pipeline");

	// Output transfer alone: exactly one item leaves
	a_count_drain: assert property (@(posedge clk) disable iff (!arst_n)
		((res_valid && !res_stall) && !(pt_valid && !pt_stall))
		|=> ($countones(stg_vld_q) == $countones($past(stg_vld_q)) - 1))
		else $error("output transfer did not retire exactly one item");
`endif

endmodule

>>> rtl/atb_xform.sv
`timescale 1ns / 1ps

module atb_xform #(
	parameter int COORD_BITS = 12
) (
	input  logic                             clk,
	input  atb_pkg::pipe_adv_t               adv,
	input  logic signed [atb_pkg::MAT_W-1:0] mat_a,
	input  logic signed [atb_pkg::MAT_W-1:0] mat_b,
	input  logic signed [atb_pkg::MAT_W-1:0] mat_c,
	input  logic signed [atb_pkg::MAT_W-1:0] mat_d,
	input  logic signed [atb_pkg::MAT_W-1:0] mat_e,
	input  logic signed [atb_pkg::MAT_W-1:0] mat_f,
	input  logic [COORD_BITS-1:0]            point_x,
	input  logic [COORD_BITS-1:0]            point_y,
	output logic signed [atb_pkg::TX_W-1:0]  tx_s2 [3],
	output logic signed [atb_pkg::TX_W-1:0]  ty_s2 [3],
	output logic [COORD_BITS-1:0]            px_s2,
	output logic [COORD_BITS-1:0]            py_s2
);
	import atb_pkg::*;

	localparam int MUL_W = MAT_W + $bits(SQRT3_VQ) - 1;

	logic signed [MUL_W-1:0] ma_s1, md_s1;
	logic [COORD_BITS-1:0]   px_s1, py_s1;
	logic signed [TX_W-1:0]  b_x, c_x, d_x, e_x, f_x, ma_x, md_x;

	// Stage 1: the only real products, a*sqrt3 and d*sqrt3
	always_ff @(posedge clk) begin
		if (adv.adv1) begin
			ma_s1 <= MUL_W'(mat_a) * MUL_W'(SQRT3_VQ);
			md_s1 <= MUL_W'(mat_d) * MUL_W'(SQRT3_VQ);
			px_s1 <= point_x;
			py_s1 <= point_y;
		end
	end

	assign b_x  = TX_W'(mat_b);
	assign c_x  = TX_W'(mat_c);
	assign d_x  = TX_W'(mat_d);
	assign e_x  = TX_W'(mat_e);
	assign f_x  = TX_W'(mat_f);
	assign ma_x = TX_W'(ma_s1);
	assign md_x = TX_W'(md_s1);

	// Stage 2: vertex y coords are 2, -1, -1 in Q2.16, so the rest are shifts
	always_ff @(posedge clk) begin
		if (adv.adv2) begin
			tx_s2[0] <= (b_x <<< 17) + (c_x <<< 16);
			tx_s2[1] <= (c_x <<< 16) - (b_x <<< 16) - ma_x;
			tx_s2[2] <= (c_x <<< 16) - (b_x <<< 16) + ma_x;
			ty_s2[0] <= (e_x <<< 17) + (f_x <<< 16);
			ty_s2[1] <= (f_x <<< 16) - (e_x <<< 16) - md_x;
			ty_s2[2] <= (f_x <<< 16) - (e_x <<< 16) + md_x;
			px_s2    <= px_s1;
			py_s2    <= py_s1;
		end
	end

endmodule

>>> rtl/atb_setup.sv
`timescale 1ns / 1ps

module atb_setup #(
	parameter int COORD_BITS = 12,
	parameter int TFRAC      = 32,
	parameter int CW         = 52,
	parameter int DW         = 53
) (
	input  logic                                  clk,
	input  atb_pkg::pipe_adv_t                    adv,
	input  logic signed [atb_pkg::TX_W-1:0]       tx_s2 [3],
	input  logic signed [atb_pkg::TX_W-1:0]       ty_s2 [3],
	input  logic [COORD_BITS-1:0]                 px_s2,
	input  logic [COORD_BITS-1:0]                 py_s2,
	input  logic [atb_pkg::FRAME_BITS-1:0]        frame_width,
	input  logic [atb_pkg::FRAME_BITS-1:0]        frame_height,
	output logic signed [DW-1:0]                  dy_s3 [3],
	output logic signed [DW-1:0]                  la_s3 [3],
	output logic signed [DW-1:0]                  ra_s3 [3],
	output logic signed [DW-1:0]                  rb_s3 [3],
	output atb_pkg::edge_side_t                   side_s3
);
	import atb_pkg::*;

	logic signed [CW-1:0] pxw, pyw, fww, fhw;
	logic signed [CW-1:0] txw [3];
	logic signed [CW-1:0] tyw [3];
	logic signed [DW-1:0] dy_c [3];
	logic signed [DW-1:0] la_c [3];
	logic signed [DW-1:0] ra_c [3];
	logic signed [DW-1:0] rb_c [3];
	edge_side_t           side_c;

	// Point and frame bounds scaled into the transformed format, no loss
	assign pxw = $signed(CW'({px_s2, {TFRAC{1'b0}}}));
	assign pyw = $signed(CW'({py_s2, {TFRAC{1'b0}}}));
	assign fww = $signed(CW'({frame_width, {TFRAC{1'b0}}}));
	assign fhw = $signed(CW'({frame_height, {TFRAC{1'b0}}}));

	// Edge terms: edge i runs from vertex i to the previous vertex j
	always_comb begin
		int j;
		logic xo, yo;
		side_c.cnt   = '0;
		side_c.dypos = '0;
		side_c.st    = ST_NONE;
		for (int i = 0; i < 3; i++) begin
			txw[i] = CW'(tx_s2[i]);
			tyw[i] = CW'(ty_s2[i]);
		end
		for (int i = 0; i < 3; i++) begin
			j = (i == 0) ? 2 : i - 1;
			side_c.cnt[i]   = (tyw[i] > pyw) ^ (tyw[j] > pyw);
			side_c.dypos[i] = tyw[j] > tyw[i];
			dy_c[i] = DW'(tyw[j]) - DW'(tyw[i]);
			la_c[i] = DW'(pxw) - DW'(txw[i]);
			ra_c[i] = DW'(txw[j]) - DW'(txw[i]);
			rb_c[i] = DW'(pyw) - DW'(tyw[i]);
		end
		// Frame check, earliest vertex wins, x before y
		for (int k = 2; k >= 0; k--) begin
			xo = (txw[k] < 0) || (txw[k] > fww);
			yo = (tyw[k] < 0) || (tyw[k] > fhw);
			if (xo) begin
				side_c.st = ST_X_OUT;
			end else if (yo) begin
				side_c.st = ST_Y_OUT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.adv3) begin
			dy_s3   <= dy_c;
			la_s3   <= la_c;
			ra_s3   <= ra_c;
			rb_s3   <= rb_c;
			side_s3 <= side_c;
		end
	end

endmodule

>>> rtl/atb_wmul.sv
`timescale 1ns / 1ps

module atb_wmul #(
	parameter int DW = 53
) (
	input  logic                     clk,
	input  atb_pkg::pipe_adv_t       adv,
	input  logic signed [DW-1:0]     op_a,
	input  logic signed [DW-1:0]     op_b,
	output logic signed [2*DW-1:0]   prod_s8
);
	import atb_pkg::*;

	localparam int H = (DW + 1) / 2;

	logic [DW-1:0]    mag_a_s4, mag_b_s4;
	logic             neg_s4, neg_s5, neg_s6, neg_s7;
	logic [2*H-1:0]   a_pad, b_pad;
	logic [2*H-1:0]   p00_s5, p01_s5, p10_s5, p11_s5;
	logic [2*H-1:0]   p00_s6, p11_s6;
	logic [2*H:0]     mid_s6;
	logic [4*H-1:0]   sum_c;
	logic [2*DW-1:0]  mag_s7;

	// Stage 4: sign and magnitude
	always_ff @(posedge clk) begin
		if (adv.adv4) begin
			mag_a_s4 <= op_a[DW-1] ? $unsigned(-op_a) : $unsigned(op_a);
			mag_b_s4 <= op_b[DW-1] ? $unsigned(-op_b) : $unsigned(op_b);
			neg_s4   <= op_a[DW-1] ^ op_b[DW-1];
		end
	end

	assign a_pad = (2*H)'(mag_a_s4);
	assign b_pad = (2*H)'(mag_b_s4);

	// Stage 5: four half-width partial products
	always_ff @(posedge clk) begin
		if (adv.adv5) begin
			p00_s5 <= (2*H)'(a_pad[H-1:0])   * (2*H)'(b_pad[H-1:0]);
			p01_s5 <= (2*H)'(a_pad[H-1:0])   * (2*H)'(b_pad[2*H-1:H]);
			p10_s5 <= (2*H)'(a_pad[2*H-1:H]) * (2*H)'(b_pad[H-1:0]);
			p11_s5 <= (2*H)'(a_pad[2*H-1:H]) * (2*H)'(b_pad[2*H-1:H]);
			neg_s5 <= neg_s4;
		end
	end

	// Stage 6: cross terms summed
	always_ff @(posedge clk) begin
		if (adv.adv6) begin
			mid_s6 <= (2*H+1)'(p01_s5) + (2*H+1)'(p10_s5);
			p00_s6 <= p00_s5;
			p11_s6 <= p11_s5;
			neg_s6 <= neg_s5;
		end
	end

	assign sum_c = {p11_s6, p00_s6} + ((4*H)'(mid_s6) << H);

	// Stage 7: full magnitude
	always_ff @(posedge clk) begin
		if (adv.adv7) begin
			mag_s7 <= sum_c[2*DW-1:0];
			neg_s7 <= neg_s6;
		end
	end

	// Stage 8: restore sign
	always_ff @(posedge clk) begin
		if (adv.adv8) begin
			prod_s8 <= neg_s7 ? -$signed(mag_s7) : $signed(mag_s7);
		end
	end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
	import atb_pkg::*;

	localparam int PIPE_GAP = 12;      // a little more than the depth of the 9-stage pipeline
	localparam int STALL_LIMIT = 1000; // cycles with no transfer on either side
	localparam longint ONE_Q = 65536;  // 1.0 in the Q2.16 vertex format

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
	} point_t;

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic        hit_in;
		edge_st_t    st;
	} hit_t;

	logic clk = 1'b0;
	logic arst_n;
	logic pt_valid;
	logic pt_stall;
	logic [11:0] point_x;
	logic [11:0] point_y;
	logic res_valid;
	logic res_stall;
	logic inside_res;
	logic [1:0] edge_status;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// Local copy of the register file
	logic signed [31:0] mat_cfg [6];
	logic [FRAME_BITS-1:0] frame_w;
	logic [FRAME_BITS-1:0] frame_h;

	point_t point_queue [$];
	hit_t expected_hits [$];
	hit_t hit_want;
	bit quiet;
	int mismatches;
	int idle_cycles;

	affine_triangle_hit_and_bounds_test uut (
		.clk(clk),
		.arst_n(arst_n),
		.pt_valid(pt_valid),
		.pt_stall(pt_stall),
		.point_x(point_x),
		.point_y(point_y),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.inside_res(inside_res),
		.edge_status(edge_status),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	// Vertex k of the mapped triangle, X or Y, with 32 fraction bits
	function automatic longint corner(int k, bit want_y);
		longint vx, vy, p, q, r;
		vx = (k == 0) ? 0 : (k == 1) ? -longint'(SQRT3_VQ) : longint'(SQRT3_VQ);
		vy = (k == 0) ? 2 * ONE_Q : -ONE_Q;
		if (want_y) begin
			p = mat_cfg[REG_MAT_D];
			q = mat_cfg[REG_MAT_E];
			r = mat_cfg[REG_MAT_F];
		end else begin
			p = mat_cfg[REG_MAT_A];
			q = mat_cfg[REG_MAT_B];
			r = mat_cfg[REG_MAT_C];
		end
		return p * vx + q * vy + r * ONE_Q;
	endfunction

	// Even-odd crossing count and first out-of-frame vertex for one point
	function automatic hit_t predict_hit(logic [11:0] x, logic [11:0] y);
		longint cx [3];
		longint cy [3];
		longint px, py, fw, fh, dy;
		logic signed [127:0] lhs, rhs, m1, m2;
		int k, j, crossings;
		bit above_k, above_j, crosses;
		hit_t r;
		for (k = 0; k < 3; k++) begin
			cx[k] = corner(k, 1'b0);
			cy[k] = corner(k, 1'b1);
		end
		px = x;
		px = px << 32;
		py = y;
		py = py << 32;
		fw = frame_w;
		fw = fw << 32;
		fh = frame_h;
		fh = fh << 32;
		// edges (V0,V2), (V1,V0), (V2,V1); divide-free intersection compare
		crossings = 0;
		for (k = 0; k < 3; k++) begin
			j = (k == 0) ? 2 : k - 1;
			above_k = cy[k] > py;
			above_j = cy[j] > py;
			if (above_k != above_j) begin
				dy = cy[j] - cy[k];
				m1 = px - cx[k];
				m2 = dy;
				lhs = m1 * m2;
				m1 = cx[j] - cx[k];
				m2 = py - cy[k];
				rhs = m1 * m2;
				crosses = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
				if (crosses)
					crossings++;
			end
		end
		r.x = x;
		r.y = y;
		r.hit_in = crossings[0];
		// x before y, vertex by vertex
		r.st = ST_NONE;
		for (k = 0; k < 3; k++) begin
			if (r.st == ST_NONE) begin
				if (cx[k] < 0 || cx[k] > fw)
					r.st = ST_X_OUT;
				else if (cy[k] < 0 || cy[k] > fh)
					r.st = ST_Y_OUT;
			end
		end
		return r;
	endfunction

	function automatic logic [11:0] clamp_coord(longint v);
		if (v < 0)
			return 12'd0;
		if (v > 4095)
			return 12'd4095;
		return v[11:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [1:0] got,
			input logic [1:0] want, input hit_t item);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t mismatch %s: got %b want %b (point %0d,%0d)", $realtime, what,
				got, want, item.x, item.y);
	endtask

	task automatic add_point(input int x, input int y);
		point_t pt;
		pt.x = x[11:0];
		pt.y = y[11:0];
		point_queue = {point_queue, pt};
	endtask

	// Wait for all transfers to finish, then for the pipe to go quiet
	task automatic settle();
		while (point_queue.size() != 0 || pt_valid || expected_hits.size() != 0)
			@(posedge clk);
		repeat (PIPE_GAP) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_FRAME_W: frame_w = val[FRAME_BITS-1:0];
			REG_FRAME_H: frame_h = val[FRAME_BITS-1:0];
			default: mat_cfg[idx] = val;
		endcase
	endtask

	task automatic load_transform(input logic [31:0] a, b, c, d, e, f, fw, fh);
		settle();
		write_reg(REG_MAT_A, a);
		write_reg(REG_MAT_B, b);
		write_reg(REG_MAT_C, c);
		write_reg(REG_MAT_D, d);
		write_reg(REG_MAT_E, e);
		write_reg(REG_MAT_F, f);
		write_reg(REG_FRAME_W, fw);
		write_reg(REG_FRAME_H, fh);
	endtask

	// Point driver: holds each transfer until accepted, predicts on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_valid <= 1'b0;
			point_x <= '0;
			point_y <= '0;
		end else begin
			if (pt_valid && !pt_stall)
				expected_hits = {expected_hits, predict_hit(point_x, point_y)};
			if (!pt_valid || !pt_stall) begin
				if (point_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= 17)) begin
					point_x <= point_queue[0].x;
					point_y <= point_queue[0].y;
					void'(point_queue.pop_front());
					pt_valid <= 1'b1;
				end else begin
					pt_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_hits.size() == 0) begin
					report_mismatch("unexpected result", {1'b0, inside_res}, 2'b00, '0);
				end else begin
					hit_want = expected_hits.pop_front();
					if (inside_res !== hit_want.hit_in)
						report_mismatch("inside_res", {1'b0, inside_res},
							{1'b0, hit_want.hit_in}, hit_want);
					if (edge_status !== hit_want.st)
						report_mismatch("edge_status", edge_status, hit_want.st, hit_want);
				end
			end
			res_stall <= !quiet && ($urandom_range(0, 99) < 17);
		end
	end

	// Watchdog on transfer activity
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((pt_valid && !pt_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", idle_cycles);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int ph, n, s, span, pick;
		longint cpx, cpy;
		logic [31:0] m [6];
		logic [31:0] fw_word, fh_word;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n <= 1'b0;
		quiet = 1'b0;
		mismatches = 0;
		mat_cfg[REG_MAT_A] = MAT_ONE;
		mat_cfg[REG_MAT_B] = '0;
		mat_cfg[REG_MAT_C] = '0;
		mat_cfg[REG_MAT_D] = '0;
		mat_cfg[REG_MAT_E] = MAT_ONE;
		mat_cfg[REG_MAT_F] = '0;
		frame_w = FRAME_W_RST;
		frame_h = FRAME_H_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset transform: tiny triangle at the origin, V1 left of the frame
		add_point(0, 0);
		add_point(0, 1);
		add_point(0, 2);
		add_point(4095, 4095);
		add_point(4095, 0);
		add_point(0, 4095);

		// 200x scale at (640,360); apex lands exactly on the top bound
		load_transform(200 << 16, 0, 640 << 16, 0, 200 << 16, 360 << 16, 4095, 760);
		add_point(640, 400);
		add_point(640, 160);
		add_point(640, 760);
		add_point(293, 160);
		add_point(987, 161);
		add_point(100, 400);
		add_point(640, 159);

		// apex one pixel over the top; upper bits of the frame word ignored
		load_transform(200 << 16, 0, 640 << 16, 0, 200 << 16, 360 << 16,
			32'hABCD_EFFF, 32'hFFFF_F2F7);
		add_point(640, 400);
		add_point(4095, 4095);

		// zero-width frame trips the x check first
		load_transform(200 << 16, 0, 640 << 16, 0, 200 << 16, 360 << 16,
			32'h8000_0000, 32'h0000_0FFF);
		add_point(640, 400);
		add_point(0, 0);

		// triangle collapsed to one point: every edge is horizontal
		load_transform(0, 0, 100 << 16, 0, 0, 50 << 16, 1280, 720);
		add_point(100, 50);
		add_point(0, 50);
		add_point(99, 50);

		// register extremes
		load_transform(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_point(0, 0);
		add_point(4095, 4095);
		load_transform(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
		add_point(0, 0);
		add_point(4095, 4095);

		// random transforms, mostly a sized and placed triangle
		for (ph = 0; ph < 10; ph++) begin
			s = $urandom_range(8, 300);
			m[0] = (s << 16) + $urandom_range(0, 65535);
			m[1] = ($urandom_range(0, s) << 16) + $urandom_range(0, 65535);
			m[2] = ($urandom_range(0, 1400) << 16) + $urandom_range(0, 65535);
			m[3] = ($urandom_range(0, s) << 16) + $urandom_range(0, 65535);
			m[4] = ($urandom_range(8, 300) << 16) + $urandom_range(0, 65535);
			m[5] = ($urandom_range(0, 800) << 16) + $urandom_range(0, 65535);
			if ($urandom_range(0, 1))
				m[0] = -m[0];
			if ($urandom_range(0, 1))
				m[1] = -m[1];
			if ($urandom_range(0, 1))
				m[3] = -m[3];
			if ($urandom_range(0, 1))
				m[4] = -m[4];
			// axis-aligned with whole-pixel vertex rows
			if (ph % 3 == 0) begin
				m[0] = {m[0][31:16], 16'h0};
				m[1] = '0;
				m[2] = {m[2][31:16], 16'h0};
				m[3] = '0;
				m[4] = {m[4][31:16], 16'h0};
				m[5] = {m[5][31:16], 16'h0};
			end
			// fully random registers
			if (ph == 7 || ph == 9) begin
				for (n = 0; n < 6; n++)
					m[n] = $urandom();
			end
			fw_word = $urandom();
			fh_word = $urandom();
			if ($urandom_range(0, 1))
				fw_word[11:0] = 12'd1280 + 12'($urandom_range(0, 600));
			if ($urandom_range(0, 1))
				fh_word[11:0] = 12'd720 + 12'($urandom_range(0, 600));
			load_transform(m[0], m[1], m[2], m[3], m[4], m[5], fw_word, fh_word);
			quiet = (ph == 4);
			cpx = $signed(m[2]) >>> 16;
			cpy = $signed(m[5]) >>> 16;
			span = 3 * s + 4;
			for (n = 0; n < 80; n++) begin
				pick = $urandom_range(0, 3);
				if (pick == 0) begin
					add_point($urandom_range(0, 4095), $urandom_range(0, 4095));
				end else if (pick == 3) begin
					// on a vertex row
					add_point(clamp_coord(cpx + $urandom_range(0, 2 * span) - span),
						clamp_coord(corner($urandom_range(0, 2), 1'b1) >>> 32));
				end else begin
					add_point(clamp_coord(cpx + $urandom_range(0, 2 * span) - span),
						clamp_coord(cpy + $urandom_range(0, 2 * span) - span));
				end
			end
		end

		settle();
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
